// ===== design/rhps_pkg.sv =====
`default_nettype none

package rhps_pkg;

	localparam logic [1:0] FN_TICK   = 2'd0;
	localparam logic [1:0] FN_LOAD   = 2'd1;
	localparam logic [1:0] FN_APPEND = 2'd2;
	localparam logic [1:0] FN_START  = 2'd3;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_UP   = 3'd1;
	localparam logic [2:0] PH_HOLD = 3'd2;
	localparam logic [2:0] PH_DOWN = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;

	localparam logic CFG_RAMP_STEP  = 1'b0;
	localparam logic CFG_HOLD_TICKS = 1'b1;

	localparam logic [15:0] RAMP_STEP_RST  = 16'd256;
	localparam logic [15:0] HOLD_TICKS_RST = 16'd50;

	localparam logic [7:0]  DUTY_FULL_IP = 8'd100;
	localparam logic [28:0] DUTY_RECIP   = 29'd1336965;

	typedef struct packed {
		logic        take;
		logic [1:0]  func;
		logic [15:0] point_value;
	} item_t;

	typedef struct packed {
		logic [15:0] level;
		logic        written;
		logic [2:0]  phase;
		logic [5:0]  point;
	} res_t;

	// integer part times 255 over 100, saturated above 100
	function automatic logic [7:0] duty_of(input logic [7:0] ip);
		logic [28:0] scaled;
		scaled = 29'(ip) * DUTY_RECIP;
		return (ip > DUTY_FULL_IP) ? 8'hFF : scaled[26:19];
	endfunction

endpackage

`default_nettype wire

// ===== design/rhps_ifs.sv =====
`default_nettype none

interface rhps_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] point_value;

	modport source (output valid, output func, output point_value, input ready);
	modport sink (input valid, input func, input point_value, output ready);
endinterface

interface rhps_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] valve_level;
	logic [7:0]  pwm_duty;
	logic        valve_written;
	logic [2:0]  phase;
	logic [5:0]  current_point;

	modport source (output valid, output valve_level, output pwm_duty, output valve_written,
		output phase, output current_point, input ready);
	modport sink (input valid, input valve_level, input pwm_duty, input valve_written,
		input phase, input current_point, output ready);
endinterface

`default_nettype wire

// ===== design/rhps_ram.sv =====
`default_nettype none

module rhps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// write-first on a collision
		if (we && waddr == raddr) begin
			rdata <= wdata;
		end else begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/rhps_seq.sv =====
`default_nettype none

module rhps_seq
	import rhps_pkg::*;
#(
	parameter int CURVE_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire item_t       item,
	input  wire logic [15:0] ramp_step,
	input  wire logic [15:0] hold_ticks,
	output res_t             res
);

	localparam int CW = $clog2(CURVE_DEPTH + 1);
	localparam int AW = (CURVE_DEPTH > 1) ? $clog2(CURVE_DEPTH) : 1;

	logic [CW-1:0] cnt_q, cnt_n;
	logic          rdy_q, rdy_n;
	logic [2:0]    ph_q, ph_n;
	logic [CW-1:0] idx_q, idx_n, idx_inc;
	logic [15:0]   lvl_q, lvl_n;
	logic [15:0]   held_q, held_n, held_inc;
	logic [16:0]   sum;
	logic [15:0]   target;
	logic          wr;
	logic          app_we;
	logic [CW+5:0] idx_wide;

	rhps_ram #(
		.WIDTH(16),
		.DEPTH(CURVE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (app_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(item.point_value),
		.raddr(idx_n[AW-1:0]),
		.rdata(target)
	);

	assign sum      = {1'b0, lvl_q} + {1'b0, ramp_step};
	assign held_inc = (held_q == 16'hFFFF) ? held_q : held_q + 16'd1;
	assign idx_inc  = idx_q + CW'(1);

	always_comb begin
		cnt_n  = cnt_q;
		rdy_n  = rdy_q;
		ph_n   = ph_q;
		idx_n  = idx_q;
		lvl_n  = lvl_q;
		held_n = held_q;
		wr     = 1'b0;
		app_we = 1'b0;
		if (item.take) begin
			unique case (item.func)
				FN_TICK: begin
					if (rdy_q) begin
						unique case (ph_q)
							PH_UP: begin
								if (lvl_q < target) begin
									lvl_n = (sum > {1'b0, target}) ? target : sum[15:0];
									wr    = 1'b1;
								end else begin
									ph_n   = PH_HOLD;
									held_n = '0;
								end
							end
							PH_HOLD: begin
								held_n = held_inc;
								if (held_inc >= hold_ticks) begin
									ph_n = PH_DOWN;
								end
							end
							PH_DOWN: begin
								if (lvl_q != 16'd0) begin
									lvl_n = (lvl_q > ramp_step) ? lvl_q - ramp_step : 16'd0;
									wr    = 1'b1;
								end else begin
									idx_n = idx_inc;
									ph_n  = (idx_inc >= cnt_q) ? PH_DONE : PH_UP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				FN_LOAD: begin
					cnt_n = '0;
					rdy_n = 1'b0;
				end
				FN_APPEND: begin
					if (cnt_q < CW'(CURVE_DEPTH)) begin
						app_we = 1'b1;
						cnt_n  = cnt_q + CW'(1);
						rdy_n  = 1'b1;
					end
				end
				FN_START: begin
					ph_n  = PH_UP;
					idx_n = '0;
					lvl_n = '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign idx_wide    = {6'd0, idx_n};
	assign res.level   = lvl_n;
	assign res.written = wr;
	assign res.phase   = ph_n;
	assign res.point   = idx_wide[5:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rdy_q  <= 1'b0;
			ph_q   <= PH_IDLE;
			idx_q  <= '0;
			lvl_q  <= '0;
			held_q <= '0;
		end else begin
			cnt_q  <= cnt_n;
			rdy_q  <= rdy_n;
			ph_q   <= ph_n;
			idx_q  <= idx_n;
			lvl_q  <= lvl_n;
			held_q <= held_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CURVE_DEPTH))
		else $error("point count beyond depth");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= CW'(CURVE_DEPTH))
		else $error("point index beyond depth");

	a_ready_count: assert property (@(posedge clk) disable iff (!arst_n)
		rdy_q |-> cnt_q != '0)
		else $error("curve ready with empty list");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(item.take && item.func == FN_TICK && !rdy_q)
		|=> ($stable(lvl_q) && $stable(ph_q) && $stable(idx_q)))
		else $error("tick without curve changed run state");
`endif

endmodule

`default_nettype wire

// ===== design/ramp_hold_profile_sequencer.sv =====
// channel | dir | handshake      | beat payload
// in      | in  | valid / ready  | func, point_value
// out     | out | valid / ready  | valve_level, pwm_duty, valve_written, phase, current_point
// cfg     | in  | cfg_we         | cfg_index, cfg_data
//
// One item per cycle while out is not stalled: the run state and curve store update at the accepting edge,
// the result beat appears on the next cycle from the result register.
// in.ready drops only while a result beat waits on a stalled out channel.
// Reset clears the run state and loads ramp_step 256, hold_ticks 50; curve store
// contents stay undefined until appended.
`default_nettype none

module ramp_hold_profile_sequencer
	import rhps_pkg::*;
#(
	parameter int CURVE_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rhps_in_if.sink          in,
	rhps_out_if.source       out,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic [15:0] ramp_q;
	logic [15:0] hold_q;
	logic        vld_q;
	item_t       item;
	res_t        res;
	res_t        res_s1;
	logic [7:0]  duty_s1;

	assign in.ready         = !vld_q || out.ready;
	assign item.take        = in.valid && in.ready;
	assign item.func        = in.func;
	assign item.point_value = in.point_value;

	rhps_seq #(
		.CURVE_DEPTH(CURVE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.ramp_step (ramp_q),
		.hold_ticks(hold_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q <= RAMP_STEP_RST;
			hold_q <= HOLD_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RAMP_STEP:  ramp_q <= cfg_data;
				CFG_HOLD_TICKS: hold_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= item.take || (vld_q && !out.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (item.take) begin
			res_s1  <= res;
			duty_s1 <= duty_of(res.level[15:8]);
		end
	end

	assign out.valid         = vld_q;
	assign out.valve_level   = res_s1.level;
	assign out.pwm_duty      = duty_s1;
	assign out.valve_written = res_s1.written;
	assign out.phase         = res_s1.phase;
	assign out.current_point = res_s1.point;

endmodule

`default_nettype wire
